/* sv/adam_pkg.sv */
// ----------------------------------------------------------------------------
// adam_pkg
// Shared types, widths and codes for the Adam element update unit.
// ----------------------------------------------------------------------------
package adam_pkg;

    localparam int ELEMENT_COUNT_DEF = 4096;

    localparam int IDX_W     = 12;
    localparam int DATA_W    = 32;
    localparam int COEF_W    = 24;
    localparam int POW_W     = 25;
    localparam int MOM2_W    = 64;
    localparam int CFG_IDX_W = 2;

    // iterative divider and square root widths
    localparam int DIV_NUM_W = 88;
    localparam int DIV_DEN_W = 33;
    localparam int SQ_IN_W   = 64;
    localparam int SQ_OUT_W  = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS = 2'd3;

    localparam logic [COEF_W-1:0] LR_RST  = 24'd16777;
    localparam logic [COEF_W-1:0] B1_RST  = 24'd15099494;
    localparam logic [COEF_W-1:0] B2_RST  = 24'd16760438;
    localparam logic [DATA_W-1:0] EPS_RST = 32'd1;
    localparam logic [POW_W-1:0]  ONE_Q24 = 25'h1000000;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SAT    = 2'd1;
    localparam logic [1:0] ST_NOSTEP = 2'd2;

    typedef struct packed {
        logic                     new_step;
        logic [IDX_W-1:0]         element_index;
        logic signed [DATA_W-1:0] gradient;
        logic signed [DATA_W-1:0] param_value;
    } t_adam_in;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [DATA_W-1:0] new_param;
        logic [1:0]               status;
    } t_adam_out;

endpackage

/* sv/adam_div.sv */
// ----------------------------------------------------------------------------
// adam_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module adam_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [adam_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [adam_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                            o_done,
    output logic [adam_pkg::DIV_NUM_W-1:0]  o_quot
);
    import adam_pkg::*;

    localparam int CW = $clog2(DIV_NUM_W);

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    assign rem_sh = {r_rem, r_num[DIV_NUM_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CW'(DIV_NUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // quotient bits shift in as numerator bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            r_num <= {r_num[DIV_NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

/* sv/adam_sqrt.sv */
// ----------------------------------------------------------------------------
// adam_sqrt
// Floor integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module adam_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [adam_pkg::SQ_IN_W-1:0]   i_rad,
    output logic                           o_done,
    output logic [adam_pkg::SQ_OUT_W-1:0]  o_root
);
    import adam_pkg::*;

    localparam int CW = $clog2(SQ_OUT_W);
    localparam int RW = SQ_OUT_W + 2;

    logic [SQ_IN_W-1:0]  r_x;
    logic [RW-1:0]       r_rem;
    logic [SQ_OUT_W-1:0] r_root;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [RW:0]         rem_sh;
    logic [RW:0]         trial;
    logic                ge;

    assign rem_sh = {r_rem[RW-2:0], r_x[SQ_IN_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CW'(SQ_OUT_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(SQ_OUT_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[SQ_IN_W-3:0], 2'b00};
            r_rem  <= ge ? RW'(rem_sh - trial) : rem_sh[RW-1:0];
            r_root <= {r_root[SQ_OUT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* sv/adam_optimizer_update_unit.sv */
// ----------------------------------------------------------------------------
// adam_optimizer_update_unit
// Per-element Adam update over first and second moment memories.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   i_in_data  (t_adam_in)
//  out       output     o_out_valid / i_out_ready o_out_data (t_adam_out)
//  cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
//  an updating transaction runs an index fold, a memory read, 9 multiply steps
//  (11 when it begins a step) on one shared 33x33 multiplier and three divider
//  passes, with a square root pass between the second and the third
//  an element before the first step passes through unchanged, status ST_NOSTEP
//  after reset both moment memories are cleared while o_in_ready is low
//  the output register lets the next transaction in while a result waits
// ----------------------------------------------------------------------------
module adam_optimizer_update_unit #(
    parameter int ELEMENT_COUNT = adam_pkg::ELEMENT_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  adam_pkg::t_adam_in              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output adam_pkg::t_adam_out             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [adam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [adam_pkg::DATA_W-1:0]     i_cfg_data
);
    import adam_pkg::*;

    localparam int AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
    localparam int AC = 90;

    // index fold by reciprocal multiplication, exact for every 12 bit index
    localparam int MOD_SH = IDX_W + AW;
    localparam longint unsigned MOD_RCP =
        ((64'd1 << MOD_SH) + 64'(ELEMENT_COUNT) - 64'd1) / 64'(ELEMENT_COUNT);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MOD  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_DM   = 4'd6;
    localparam logic [3:0] S_DV   = 4'd7;
    localparam logic [3:0] S_SQ   = 4'd8;
    localparam logic [3:0] S_DU   = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    localparam logic [3:0] OP_P1 = 4'd0;
    localparam logic [3:0] OP_P2 = 4'd1;
    localparam logic [3:0] OP_M1 = 4'd2;
    localparam logic [3:0] OP_M2 = 4'd3;
    localparam logic [3:0] OP_G2 = 4'd4;
    localparam logic [3:0] OP_V1 = 4'd5;
    localparam logic [3:0] OP_V2 = 4'd6;
    localparam logic [3:0] OP_V3 = 4'd7;
    localparam logic [3:0] OP_V4 = 4'd8;
    localparam logic [3:0] OP_T1 = 4'd9;
    localparam logic [3:0] OP_T2 = 4'd10;

    localparam logic [AC-1:0] HALF_ACC = AC'(1) << 23;

    // configuration
    logic [COEF_W-1:0] r_lr, r_b1, r_b2;
    logic [DATA_W-1:0] r_eps;

    // control
    logic [3:0]   r_state;
    logic [3:0]   r_op;
    logic [AW:0]  r_clr;
    logic [3:0]   r_mod_cnt;
    logic         r_begun;
    logic         r_div_go;
    logic         r_sq_go;
    logic         r_out_valid;

    // datapath
    t_adam_in             r_in;
    t_adam_out            r_out;
    logic [IDX_W-1:0]     r_mod_q;
    logic [AW-1:0]        r_mod_rem;
    logic [POW_W-1:0]     r_pw1, r_pw2;
    logic [DATA_W-1:0]    r_rd_m;
    logic [MOM2_W-1:0]    r_rd_v;
    logic signed [65:0]   r_prod;
    logic [AC-1:0]        r_acc;
    logic [DATA_W-1:0]    r_m;
    logic [MOM2_W-1:0]    r_g2;
    logic [MOM2_W-1:0]    r_v;
    logic [55:0]          r_mhat;
    logic [MOM2_W-1:0]    r_t;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DATA_W-1:0]    r_res_param;
    logic [1:0]           r_res_status;

    logic [DATA_W-1:0]    r_mem_m [ELEMENT_COUNT];
    logic [MOM2_W-1:0]    r_mem_v [ELEMENT_COUNT];

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic [39:0]          mod_prod;
    logic [IDX_W-1:0]     mod_q;
    logic [39:0]          mod_qn;
    logic [AW-1:0]        mod_rem;
    logic [AW-1:0]        slot;
    logic [POW_W-1:0]     c1, c2, d1, d2;
    logic [DATA_W-1:0]    gabs, mabs;
    logic signed [32:0]   mul_a, mul_b;
    logic [AC-1:0]        prod_ext, term, base, acc_sum;
    logic                 acc_shift;
    logic                 div_done, sq_done;
    logic [DIV_NUM_W-1:0] div_num, div_quot;
    logic [DIV_DEN_W-1:0] div_den;
    logic [SQ_OUT_W-1:0]  sq_root;
    logic [MOM2_W-1:0]    vhat;
    logic [DIV_DEN_W-1:0] den_sum;
    logic [48:0]          u_step;
    logic [50:0]          res;
    logic                 ovf_hi, ovf_lo;
    logic                 in_fire, out_free, mem_we;
    logic [AW-1:0]        mem_waddr;

    // the quotient is registered first; the remainder then uses the registered quotient
    assign mod_prod = 40'(r_in.element_index) * 40'(MOD_RCP);
    assign mod_q    = IDX_W'(mod_prod >> MOD_SH);
    assign mod_qn   = 40'(r_mod_q) * 40'(ELEMENT_COUNT);
    assign mod_rem  = AW'(40'(r_in.element_index) - mod_qn);
    assign slot     = r_mod_rem;

    assign c1 = ONE_Q24 - {1'b0, r_b1};
    assign c2 = ONE_Q24 - {1'b0, r_b2};
    assign d1 = (r_pw1 == ONE_Q24) ? POW_W'(1) : ONE_Q24 - r_pw1;
    assign d2 = (r_pw2 == ONE_Q24) ? POW_W'(1) : ONE_Q24 - r_pw2;

    assign gabs = r_in.gradient[DATA_W-1] ? -r_in.gradient : r_in.gradient;
    assign mabs = r_m[DATA_W-1] ? -r_m : r_m;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_op)
            OP_P1: begin mul_a = 33'(r_pw1); mul_b = 33'(r_b1); end
            OP_P2: begin mul_a = 33'(r_pw2); mul_b = 33'(r_b2); end
            OP_M1: begin mul_a = 33'($signed(r_rd_m)); mul_b = 33'(r_b1); end
            OP_M2: begin mul_a = 33'(r_in.gradient); mul_b = 33'(c1); end
            OP_G2: begin mul_a = 33'(gabs); mul_b = 33'(gabs); end
            OP_V1: begin mul_a = 33'(r_rd_v[31:0]); mul_b = 33'(r_b2); end
            OP_V2: begin mul_a = 33'(r_rd_v[63:32]); mul_b = 33'(r_b2); end
            OP_V3: begin mul_a = 33'(r_g2[31:0]); mul_b = 33'(c2); end
            OP_V4: begin mul_a = 33'(r_g2[63:32]); mul_b = 33'(c2); end
            OP_T1: begin mul_a = 33'(r_mhat[31:0]); mul_b = 33'(r_lr); end
            OP_T2: begin mul_a = 33'(r_mhat[55:32]); mul_b = 33'(r_lr); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // accumulate the registered product, upper halves weighted by 2^32
    assign acc_shift = r_op inside {OP_V2, OP_V4, OP_T2};
    assign prod_ext  = {{(AC-66){r_prod[65]}}, r_prod};
    assign term      = acc_shift ? {prod_ext[AC-33:0], 32'b0} : prod_ext;

    always_comb begin
        case (r_op)
            OP_P1, OP_P2, OP_M1, OP_V1: base = HALF_ACC;
            OP_G2, OP_T1:               base = '0;
            default:                    base = r_acc;
        endcase
    end
    assign acc_sum = base + term;

    // divider operands follow the phase
    always_comb begin
        case (r_state)
            S_DM: begin
                div_num = {32'b0, mabs, 24'b0};
                div_den = 33'(d1);
            end
            S_DV: begin
                div_num = {r_v, 24'b0};
                div_den = 33'(d2);
            end
            default: begin
                div_num = {16'b0, r_t, 8'b0};
                div_den = r_den;
            end
        endcase
    end

    assign vhat    = (|div_quot[DIV_NUM_W-1:MOM2_W]) ? '1 : div_quot[MOM2_W-1:0];
    assign den_sum = 33'(sq_root) + 33'(r_eps);
    assign u_step  = (div_quot > (DIV_NUM_W'(1) << 48)) ? (49'(1) << 48) : div_quot[48:0];
    assign res     = r_m[DATA_W-1]
                   ? {{19{r_in.param_value[31]}}, r_in.param_value} + {2'b0, u_step}
                   : {{19{r_in.param_value[31]}}, r_in.param_value} - {2'b0, u_step};
    assign ovf_hi  = !res[50] && (|res[50:31]);
    assign ovf_lo  = res[50] && !(&res[50:31]);

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign mem_we   = (r_state == S_CLR)
                   || ((r_state == S_ACC) && ((r_op == OP_M2) || (r_op == OP_V4)));
    assign mem_waddr = (r_state == S_CLR) ? r_clr[AW-1:0] : slot;

    // ------------------------------------------------------------------
    // iterative units
    // ------------------------------------------------------------------
    adam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    adam_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_go),
        .i_rad   (vhat),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // ------------------------------------------------------------------
    // moment memories
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we && ((r_state == S_CLR) || (r_op == OP_M2))) begin
            r_mem_m[mem_waddr] <= (r_state == S_CLR) ? '0 : acc_sum[55:24];
        end
        if (mem_we && ((r_state == S_CLR) || (r_op == OP_V4))) begin
            r_mem_v[mem_waddr] <= (r_state == S_CLR) ? '0 : acc_sum[87:24];
        end
        if (r_state == S_RD) begin
            r_rd_m <= r_mem_m[slot];
            r_rd_v <= r_mem_v[slot];
        end
    end

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= LR_RST;
            r_b1  <= B1_RST;
            r_b2  <= B2_RST;
            r_eps <= EPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LR:  r_lr  <= i_cfg_data[COEF_W-1:0];
                CFG_B1:  r_b1  <= i_cfg_data[COEF_W-1:0];
                CFG_B2:  r_b2  <= i_cfg_data[COEF_W-1:0];
                CFG_EPS: r_eps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_op        <= OP_P1;
            r_clr       <= '0;
            r_mod_cnt   <= '0;
            r_begun     <= 1'b0;
            r_div_go    <= 1'b0;
            r_sq_go     <= 1'b0;
            r_out_valid <= 1'b0;
            r_pw1       <= ONE_Q24;
            r_pw2       <= ONE_Q24;
        end else begin
            r_div_go <= ((r_state == S_ACC) && (r_op inside {OP_V4, OP_T2}))
                     || ((r_state == S_SQ) && sq_done);
            r_sq_go  <= (r_state == S_DV) && div_done;
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(ELEMENT_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_mod_cnt <= '0;
                        if (i_in_data.new_step) begin
                            r_begun <= 1'b1;
                        end
                        if (!i_in_data.new_step && !r_begun) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    r_mod_cnt <= r_mod_cnt + 1'b1;
                    if (r_mod_cnt == 4'd1) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_op    <= r_in.new_step ? OP_P1 : OP_M1;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_op == OP_V4) begin
                        r_state <= S_DM;
                    end else if (r_op == OP_T2) begin
                        r_state <= S_DV;
                    end else begin
                        r_state <= S_MUL;
                    end
                    case (r_op)
                        OP_P1: begin
                            r_pw1 <= acc_sum[48:24];
                            r_op  <= OP_P2;
                        end
                        OP_P2: begin
                            r_pw2 <= acc_sum[48:24];
                            r_op  <= OP_M1;
                        end
                        OP_M1: r_op <= OP_M2;
                        OP_M2: r_op <= OP_G2;
                        OP_G2: r_op <= OP_V1;
                        OP_V1: r_op <= OP_V2;
                        OP_V2: r_op <= OP_V3;
                        OP_V3: r_op <= OP_V4;
                        OP_T1: r_op <= OP_T2;
                        default: ;
                    endcase
                end
                S_DM: begin
                    if (div_done) begin
                        r_op    <= OP_T1;
                        r_state <= S_MUL;
                    end
                end
                S_DV: begin
                    if (div_done) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (sq_done) begin
                        r_state <= S_DU;
                    end
                end
                S_DU: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_fire) begin
            r_in         <= i_in_data;
            r_res_param  <= i_in_data.param_value;
            r_res_status <= ST_NOSTEP;
        end
        if (r_state == S_MOD) begin
            r_mod_q   <= mod_q;
            r_mod_rem <= mod_rem;
        end
        if (r_state == S_ACC) begin
            r_acc <= acc_sum;
            case (r_op)
                OP_M2:   r_m  <= acc_sum[55:24];
                OP_G2:   r_g2 <= r_prod[63:0];
                OP_V4:   r_v  <= acc_sum[87:24];
                OP_T2:   r_t  <= acc_sum[79:16];
                default: ;
            endcase
        end
        if ((r_state == S_DM) && div_done) begin
            r_mhat <= div_quot[55:0];
        end
        if ((r_state == S_SQ) && sq_done) begin
            r_den <= (den_sum == '0) ? DIV_DEN_W'(1) : den_sum;
        end
        if ((r_state == S_DU) && div_done) begin
            if (ovf_hi) begin
                r_res_param  <= 32'h7fff_ffff;
                r_res_status <= ST_SAT;
            end else if (ovf_lo) begin
                r_res_param  <= 32'h8000_0000;
                r_res_status <= ST_SAT;
            end else begin
                r_res_param  <= res[31:0];
                r_res_status <= ST_OK;
            end
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out.out_index <= r_in.element_index;
            r_out.new_param <= r_res_param;
            r_out.status    <= r_res_status;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Adam element update unit. Elements go in over
// a valid/ready channel; an in-bench fixed point model of the moment
// memories and beta powers predicts each result. Results are compared in
// order, field by field. Configuration changes happen only while idle.
// ----------------------------------------------------------------------------
module tb_top;
    import adam_pkg::*;

    localparam int  NUM_ELEM    = 4096;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam longint unsigned Q24   = 64'd1 << 24;
    localparam longint unsigned U_CAP = 64'd1 << 48;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_adam_in  in_data;
    logic      out_valid;
    logic      out_ready;
    t_adam_out out_data;
    logic      cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    adam_optimizer_update_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // model state
    logic [COEF_W-1:0] lr_q, b1_q, b2_q;
    logic [DATA_W-1:0] eps_q;
    int                m_mem [NUM_ELEM];
    longint unsigned   v_mem [NUM_ELEM];
    longint unsigned   pow1, pow2;
    bit                step_begun;

    t_adam_out expected_updates[$];
    int        errors;
    int        items_sent;
    int        results_seen;
    int        cycles;
    bit        idle_en;
    int        out_stall;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_adam_out adam_update(t_adam_in it);
        t_adam_out       r;
        int              slot;
        longint          g, p, num, m, res;
        longint unsigned mag, g2, v, hi, lo, d1, d2, mabs, mhat, vhat;
        longint unsigned q, rm, den, t, u;
        r.out_index = it.element_index;
        slot = it.element_index % NUM_ELEM;
        if (it.new_step) begin
            pow1 = (pow1 * b1_q + (Q24 >> 1)) >> 24;
            pow2 = (pow2 * b2_q + (Q24 >> 1)) >> 24;
            step_begun = 1'b1;
        end
        if (!step_begun) begin
            r.new_param = it.param_value;
            r.status    = ST_NOSTEP;
            return r;
        end
        g = longint'(it.gradient);
        p = longint'(it.param_value);
        num = longint'(b1_q) * longint'(m_mem[slot]) + (longint'(Q24) - longint'(b1_q)) * g;
        m_mem[slot] = int'((num + longint'(Q24 >> 1)) >>> 24);
        mag = (g < 0) ? longint'(-g) : longint'(g);
        g2  = mag * mag;
        v   = v_mem[slot];
        hi  = longint'(b2_q) * (v >> 24) + (Q24 - b2_q) * (g2 >> 24);
        lo  = longint'(b2_q) * (v & 64'hFFFFFF) + (Q24 - b2_q) * (g2 & 64'hFFFFFF)
              + (Q24 >> 1);
        v_mem[slot] = hi + (lo >> 24);

        m  = longint'(m_mem[slot]);
        v  = v_mem[slot];
        d1 = Q24 - pow1;
        d2 = Q24 - pow2;
        if (d1 == 0) d1 = 1;
        if (d2 == 0) d2 = 1;
        mabs = (m < 0) ? longint'(-m) : longint'(m);
        mhat = (mabs << 24) / d1;
        q  = v / d2;
        rm = v % d2;
        if (q >= (64'd1 << 40)) vhat = '1;
        else vhat = (q << 24) + ((rm << 24) / d2);
        den = int_sqrt(vhat) + longint'(eps_q);
        if (den == 0) den = 1;
        t  = (mhat >> 16) * lr_q + (((mhat & 64'hFFFF) * lr_q) >> 16);
        q  = t / den;
        rm = t % den;
        if (q >= (64'd1 << 40)) u = U_CAP;
        else u = (q << 8) + ((rm << 8) / den);
        if (u > U_CAP) u = U_CAP;
        res = (m < 0) ? p + longint'(u) : p - longint'(u);
        if (res > 64'sd2147483647) begin
            r.new_param = 32'h7FFFFFFF;
            r.status    = ST_SAT;
        end else if (res < -64'sd2147483648) begin
            r.new_param = 32'h80000000;
            r.status    = ST_SAT;
        end else begin
            r.new_param = res[31:0];
            r.status    = ST_OK;
        end
        return r;
    endfunction

    // output side: random back-pressure in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b1;
            out_stall <= 0;
        end else if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            out_ready <= (out_stall == 1);
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            out_stall <= $urandom_range(1, 5);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_adam_out exp_r;
        if (i_rst_n && out_valid && out_ready) begin
            results_seen <= results_seen + 1;
            if (expected_updates.size() == 0) begin
                $error("unexpected result index %0d", out_data.out_index);
                errors = errors + 1;
            end else begin
                exp_r = expected_updates.pop_front();
                if (out_data.out_index !== exp_r.out_index) begin
                    $error("out_index exp %0d got %0d", exp_r.out_index, out_data.out_index);
                    errors = errors + 1;
                end
                if (out_data.new_param !== exp_r.new_param) begin
                    $error("new_param exp %0h got %0h", exp_r.new_param, out_data.new_param);
                    errors = errors + 1;
                end
                if (out_data.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, out_data.status);
                    errors = errors + 1;
                end
            end
        end
    end

    task automatic send_element(t_adam_in it);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        expected_updates = {expected_updates, adam_update(it)};
        items_sent++;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_updates.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LR:  lr_q  = val[COEF_W-1:0];
            CFG_B1:  b1_q  = val[COEF_W-1:0];
            CFG_B2:  b2_q  = val[COEF_W-1:0];
            CFG_EPS: eps_q = val;
            default: ;
        endcase
    endtask

    function automatic t_adam_in mk(bit ns, int idx, logic [31:0] g, logic [31:0] p);
        t_adam_in it;
        it.new_step      = ns;
        it.element_index = idx[IDX_W-1:0];
        it.gradient      = g;
        it.param_value   = p;
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
            1:       return $urandom_range(0, 32'hFFF) - 32'h7FF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_passthrough();
        send_element(mk(0, 0, 32'h7FFFFFFF, 32'h80000000));
        send_element(mk(0, 4095, 32'h80000000, 32'h7FFFFFFF));
        send_element(mk(0, 7, 32'h0, 32'hFFFFFFFF));
        send_element(mk(0, 123, 32'h12345678, 32'h0));
    endtask

    task automatic test_first_steps();
        send_element(mk(1, 0, 32'h00010000, 32'h00010000));
        send_element(mk(0, 4095, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_element(mk(0, 1, 32'h80000000, 32'h80000000));
        send_element(mk(0, 2, 32'h0, 32'h0));
        send_element(mk(1, 0, 32'hFFFF0000, 32'h00010000));
        send_element(mk(0, 0, 32'h00000001, 32'hFFFFFFFF));
        send_element(mk(1, 4095, 32'h80000000, 32'h00000000));
    endtask

    task automatic test_saturation();
        write_reg(CFG_LR, 32'h00FFFFFF);
        write_reg(CFG_EPS, 32'h0);
        // zero denominator on an untouched slot
        send_element(mk(0, 300, 32'h0, 32'h00050000));
        send_element(mk(1, 301, 32'h7FFFFFFF, 32'h80000001));
        send_element(mk(0, 302, 32'h80000000, 32'h7FFFFFFE));
        send_element(mk(0, 303, 32'h00000001, 32'h7FFFFFFF));
        write_reg(CFG_EPS, 32'hFFFFFFFF);
        send_element(mk(0, 301, 32'h7FFFFFFF, 32'h0));
        write_reg(CFG_LR, 32'h0);
        send_element(mk(1, 302, 32'h12345678, 32'h55555555));
    endtask

    task automatic test_beta_extremes();
        write_reg(CFG_LR, LR_RST);
        write_reg(CFG_EPS, EPS_RST);
        write_reg(CFG_B1, 32'h0);
        write_reg(CFG_B2, 32'h0);
        send_element(mk(1, 10, 32'h00020000, 32'h00100000));
        send_element(mk(0, 10, 32'hFFFE0000, 32'h00100000));
        write_reg(CFG_B1, 32'h00FFFFFF);
        write_reg(CFG_B2, 32'h00FFFFFF);
        send_element(mk(1, 11, 32'h40000000, 32'h00000000));
        send_element(mk(0, 11, 32'hC0000000, 32'h00000000));
    endtask

    task automatic test_pressure();
        send_element(mk(1, 20, 32'h00008000, 32'h00010000));
        drain();
        send_element(mk(0, 20, 32'hFFFF8000, 32'h00010000));
    endtask

    task automatic run_random(int n, int idx_span);
        int k;
        for (k = 0; k < n; k++) begin
            send_element(mk($urandom_range(0, 7) == 0,
                            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                        : $urandom_range(0, idx_span),
                            rand_word(), rand_word()));
        end
    endtask

    task automatic test_random();
        int ph;
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_B1, B1_RST);
                    write_reg(CFG_B2, B2_RST);
                end
                1: write_reg(CFG_LR, $urandom_range(0, 24'hFFFFFF));
                2: begin
                    write_reg(CFG_B1, $urandom_range(24'h800000, 24'hFFFFFF));
                    write_reg(CFG_B2, $urandom_range(24'hF00000, 24'hFFFFFF));
                    write_reg(CFG_EPS, $urandom);
                end
                3: begin
                    write_reg(CFG_LR, 32'h00FFFFFF);
                    write_reg(CFG_EPS, $urandom_range(0, 16));
                end
                4: begin
                    write_reg(CFG_B1, $urandom_range(0, 24'hFFFFFF));
                    write_reg(CFG_B2, $urandom_range(0, 24'hFFFFFF));
                end
                default: begin
                    write_reg(CFG_LR, LR_RST);
                    write_reg(CFG_EPS, EPS_RST);
                    idle_en = 1'b0;
                end
            endcase
            run_random(260, 31);
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        out_ready = 1'b1;
        out_stall = 0;
        cycles    = 0;
        errors    = 0;
        items_sent   = 0;
        results_seen = 0;
        idle_en    = 1'b1;
        lr_q  = LR_RST;
        b1_q  = B1_RST;
        b2_q  = B2_RST;
        eps_q = EPS_RST;
        pow1  = ONE_Q24;
        pow2  = ONE_Q24;
        step_begun = 1'b0;
        for (int i = 0; i < NUM_ELEM; i++) begin
            m_mem[i] = 0;
            v_mem[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough();
        test_first_steps();
        test_saturation();
        test_beta_extremes();
        test_pressure();
        test_random();

        drain();
        repeat (400) @(posedge i_clk);
        $display("covered %0d elements, %0d results checked, %0d mismatches",
                 items_sent, results_seen, errors);
        $display("pass-through, saturation, zero-beta and full-beta settings, random phases");
        if (errors == 0 && expected_updates.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
